### sv/rump_pkg.sv
// ----------------------------------------------------------------------------
// rump_pkg
// Shared types and constants of the route update message packer.
// ----------------------------------------------------------------------------
`default_nettype none

package rump_pkg;

  // Widths of the fields and of the internal byte counts.
  localparam int unsigned PlenW     = 6;
  localparam int unsigned AsCntW    = 8;
  localparam int unsigned CommCntW  = 6;
  localparam int unsigned SizeW     = 16;
  localparam int unsigned CountW    = 16;
  localparam int unsigned OvhW      = 11;
  localparam int unsigned PsizeW    = 4;

  // Fixed message overhead: 19 byte header, two 2 byte length fields,
  // origin 4, as path base 5, next hop 7, local pref 7 and med 7.
  localparam int unsigned BaseOverhead  = 19 + 2 * 2 + 4 + 5 + 7 + 7 + 7;
  localparam int unsigned CommBaseBytes = 3;
  localparam int unsigned AtomicBytes   = 3;
  localparam int unsigned AggrBytes     = 9;

  localparam logic [SizeW-1:0] MaxSizeReset = SizeW'(4096);

  // Result queue geometry.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  typedef struct packed {
    logic [PlenW-1:0]    prefix_len;
    logic                first_of_group;
    logic                last_of_group;
    logic [AsCntW-1:0]   as_path_count;
    logic [CommCntW-1:0] community_count;
    logic                atomic_agg;
    logic                aggregator_present;
  } item_t;

  typedef struct packed {
    logic [SizeW-1:0]  msg_bytes;
    logic [CountW-1:0] prefix_count;
    logic              group_end;
    logic              last_result;
  } result_t;

  // Results handed to the queue in one cycle: up to two, in order.
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

### sv/rump_overhead.sv
// ----------------------------------------------------------------------------
// rump_overhead
// Per item cost terms: fixed message overhead of the group and prefix bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module rump_overhead (
  input  wire rump_pkg::item_t          item,
  output logic [rump_pkg::OvhW-1:0]    overhead,
  output logic [rump_pkg::PsizeW-1:0]  psize
);

  logic [rump_pkg::OvhW-1:0] as_bytes;
  logic [rump_pkg::OvhW-1:0] comm_bytes;
  logic [rump_pkg::OvhW-1:0] flag_bytes;

  always_comb begin
    as_bytes   = {1'b0, item.as_path_count, 2'b00};
    comm_bytes = '0;
    if (item.community_count != '0) begin
      comm_bytes = rump_pkg::OvhW'(rump_pkg::CommBaseBytes)
                 + {3'b000, item.community_count, 2'b00};
    end
    flag_bytes = '0;
    if (item.atomic_agg) begin
      flag_bytes = rump_pkg::OvhW'(rump_pkg::AtomicBytes);
    end
    if (item.aggregator_present) begin
      flag_bytes = flag_bytes + rump_pkg::OvhW'(rump_pkg::AggrBytes);
    end
    overhead = rump_pkg::OvhW'(rump_pkg::BaseOverhead) + as_bytes + comm_bytes + flag_bytes;
  end

  // One length byte plus the address bytes, ceil(length / 8).
  assign psize = rump_pkg::PsizeW'(1)
               + rump_pkg::PsizeW'((7'(item.prefix_len) + 7'd7) >> 3);

endmodule

`default_nettype wire

### sv/rump_result_fifo.sv
// ----------------------------------------------------------------------------
// rump_result_fifo
// Small result queue that takes up to two results a cycle and gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module rump_result_fifo (
  input  wire                            clk,
  input  wire                            rst,
  input  wire rump_pkg::push_t           push,
  output logic [rump_pkg::FifoAw:0]      count,
  output logic                           result_valid,
  input  wire                            result_ready,
  output rump_pkg::result_t              result
);

  rump_pkg::result_t               entries [rump_pkg::FifoDepth];
  logic [rump_pkg::FifoAw-1:0]     wr_ptr;
  logic [rump_pkg::FifoAw-1:0]     rd_ptr;
  logic [rump_pkg::FifoAw-1:0]     wr_ptr_plus1;
  logic                            pop;

  assign pop          = result_valid && result_ready;
  assign wr_ptr_plus1 = wr_ptr + 1'b1;
  assign result_valid = (count != '0);
  assign result       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + rump_pkg::FifoAw'(push.num);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (rump_pkg::FifoAw+1)'(push.num) - (rump_pkg::FifoAw+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.num == 2'd2) begin
      entries[wr_ptr_plus1] <= push.second;
    end
  end

endmodule

`default_nettype wire

### sv/route_update_message_packer_unit.sv
// ----------------------------------------------------------------------------
// route_update_message_packer_unit
// Greedy packer of route prefixes into routing update messages.
// ----------------------------------------------------------------------------
// Usage: route prefixes arrive on the item channel (item_valid/item_ready),
// one request per prefix, grouped by shared path attributes. The item that
// starts a group carries the attribute counts and flags. Each request is first
// captured in an input register, together with its group overhead and prefix
// byte cost, which are worked out on the way in. Once the queue has room for two
// reports, one pass of short logic updates the open message and pushes zero,
// one or two closed message reports into a four entry result queue that drives
// the result channel (result_valid/result_ready). A report passes through the
// input register and a queue entry before it is offered on the result port.
// Throughput is one request per cycle while the queue has room for two reports;
// the single add and compare on the open message byte count sets that rate.
// Only a request that closes two messages at once can outrun a one per cycle
// result drain, so when the receiver stalls the queue fills and item_ready
// drops as soon as fewer than two queue entries are free for the held request;
// nothing is lost or repeated.
// The cfg channel writes max_msg_bytes at any time it is offered; the value is
// taken when a group start is processed. Reset (rst, synchronous) empties the
// queue and the input register, clears the open message and the group state,
// and loads max_msg_bytes with 4096.
// ----------------------------------------------------------------------------
`default_nettype none

module route_update_message_packer_unit (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             item_valid,
  output logic                            item_ready,
  input  wire rump_pkg::item_t            item,
  output logic                            result_valid,
  input  wire                             result_ready,
  output rump_pkg::result_t               result,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [rump_pkg::SizeW-1:0]       cfg_data
);

  // Configuration register.
  logic [rump_pkg::SizeW-1:0]  max_msg_bytes;

  // Input register with the precomputed cost terms.
  logic                           held_valid;
  logic                           held_first;
  logic                           held_last;
  logic [rump_pkg::OvhW-1:0]      held_overhead;
  logic [rump_pkg::PsizeW-1:0]    held_psize;
  logic [rump_pkg::OvhW-1:0]      in_overhead;
  logic [rump_pkg::PsizeW-1:0]    in_psize;

  // Group and open message state.
  logic [rump_pkg::OvhW-1:0]      fixed_overhead_bytes;
  logic [rump_pkg::SizeW-1:0]     nlri_space_limit;
  logic [rump_pkg::SizeW-1:0]     open_nlri_bytes;
  logic [rump_pkg::CountW-1:0]    open_prefix_count;
  logic [rump_pkg::OvhW-1:0]      fixed_overhead_bytes_next;
  logic [rump_pkg::SizeW-1:0]     nlri_space_limit_next;
  logic [rump_pkg::SizeW-1:0]     open_nlri_bytes_next;
  logic [rump_pkg::CountW-1:0]    open_prefix_count_next;

  // Single pass datapath.
  logic                           go;
  logic [rump_pkg::FifoAw:0]      queue_count;
  logic [rump_pkg::SizeW-1:0]     bytes_eff;
  logic [rump_pkg::CountW-1:0]    count_eff;
  logic [rump_pkg::SizeW:0]       bytes_sum;
  logic                           close_group;
  logic                           close_full;
  logic [rump_pkg::SizeW-1:0]     bytes_after;
  logic [rump_pkg::CountW-1:0]    count_after;
  rump_pkg::result_t              res_group;
  rump_pkg::result_t              res_full;
  rump_pkg::result_t              res_last;
  rump_pkg::push_t                push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_msg_bytes <= rump_pkg::MaxSizeReset;
    end else if (cfg_valid && cfg_ready) begin
      max_msg_bytes <= cfg_data;
    end
  end

  rump_overhead u_overhead (
    .item     (item),
    .overhead (in_overhead),
    .psize    (in_psize)
  );

  // The held request is processed when the queue can take two more reports.
  assign go         = held_valid
                   && (queue_count <= (rump_pkg::FifoAw+1)'(rump_pkg::FifoDepth - 2));
  assign item_ready = !held_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held_first    <= item.first_of_group;
      held_last     <= item.last_of_group;
      held_overhead <= in_overhead;
      held_psize    <= in_psize;
    end
  end

  always_comb begin
    // A new group drops the open message (after reporting it) and loads
    // its overhead and the space left for prefixes.
    fixed_overhead_bytes_next = fixed_overhead_bytes;
    nlri_space_limit_next     = nlri_space_limit;
    bytes_eff                 = open_nlri_bytes;
    count_eff                 = open_prefix_count;
    close_group               = 1'b0;
    if (held_first) begin
      close_group               = (open_prefix_count != '0);
      fixed_overhead_bytes_next = held_overhead;
      if (max_msg_bytes > rump_pkg::SizeW'(held_overhead)) begin
        nlri_space_limit_next = max_msg_bytes - rump_pkg::SizeW'(held_overhead);
      end else begin
        nlri_space_limit_next = '0;
      end
      bytes_eff = '0;
      count_eff = '0;
    end

    // Greedy fit: a non-empty message that cannot take this prefix closes.
    bytes_sum  = (rump_pkg::SizeW+1)'(bytes_eff) + (rump_pkg::SizeW+1)'(held_psize);
    close_full = (count_eff != '0)
              && (bytes_sum > (rump_pkg::SizeW+1)'(nlri_space_limit_next));
    if (close_full) begin
      bytes_after = rump_pkg::SizeW'(held_psize);
      count_after = rump_pkg::CountW'(1);
    end else begin
      bytes_after = bytes_sum[rump_pkg::SizeW-1:0];
      count_after = count_eff + 1'b1;
    end

    res_group.msg_bytes    = rump_pkg::SizeW'(fixed_overhead_bytes) + open_nlri_bytes;
    res_group.prefix_count = open_prefix_count;
    res_group.group_end    = 1'b1;
    res_group.last_result  = !held_last;

    res_full.msg_bytes     = rump_pkg::SizeW'(fixed_overhead_bytes_next) + bytes_eff;
    res_full.prefix_count  = count_eff;
    res_full.group_end     = 1'b0;
    res_full.last_result   = !held_last;

    res_last.msg_bytes     = rump_pkg::SizeW'(fixed_overhead_bytes_next) + bytes_after;
    res_last.prefix_count  = count_after;
    res_last.group_end     = 1'b1;
    res_last.last_result   = 1'b1;

    // The group close and the full close never happen together, and the
    // group end report always comes last.
    push.num    = 2'(close_group) + 2'(close_full) + 2'(held_last);
    push.second = res_last;
    if (close_group) begin
      push.first = res_group;
    end else if (close_full) begin
      push.first = res_full;
    end else begin
      push.first = res_last;
    end
    if (!go) begin
      push.num = 2'd0;
    end

    if (held_last) begin
      open_nlri_bytes_next   = '0;
      open_prefix_count_next = '0;
    end else begin
      open_nlri_bytes_next   = bytes_after;
      open_prefix_count_next = count_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_overhead_bytes <= '0;
      nlri_space_limit     <= '0;
      open_nlri_bytes      <= '0;
      open_prefix_count    <= '0;
    end else if (go) begin
      fixed_overhead_bytes <= fixed_overhead_bytes_next;
      nlri_space_limit     <= nlri_space_limit_next;
      open_nlri_bytes      <= open_nlri_bytes_next;
      open_prefix_count    <= open_prefix_count_next;
    end
  end

  rump_result_fifo u_result_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .count        (queue_count),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // The result queue never holds more reports than it has entries.
  assert property (@(posedge clk) disable iff (rst)
    queue_count <= (rump_pkg::FifoAw+1)'(rump_pkg::FifoDepth))
    else $error("result queue overflow");

  // A processed group end leaves no open message behind.
  assert property (@(posedge clk) disable iff (rst)
    go && held_last |=> open_prefix_count == '0 && open_nlri_bytes == '0)
    else $error("open message survives the group end");

  // Every prefix costs at least one byte, so an open message with prefixes never has zero bytes.
  assert property (@(posedge clk) disable iff (rst)
    open_prefix_count != '0 |-> open_nlri_bytes != '0)
    else $error("open message has prefixes but no bytes");

  // Input back pressure only happens while a request is held.
  assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> held_valid && !go)
    else $error("input stalled without a held request");

endmodule

`default_nettype wire

### dv/route_update_message_packer_unit_tb.sv
// ----------------------------------------------------------------------------
// route_update_message_packer_unit_tb
// Self-checking testbench of the route update message packer.
// A short table of directed prefix requests runs first. Some of its rows carry
// hand-computed reports and the rest are checked against a built-in packing
// predictor. Random attribute groups follow under several message size limits.
// The sender works in bursts and the receiver stalls on a window pattern.
// ----------------------------------------------------------------------------
module route_update_message_packer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Byte costs of one update message, from header to optional attributes.
  localparam int unsigned HeaderLenBytes  = 19 + 2 * 2;
  localparam int unsigned MandatoryBytes  = 4 + 5 + 7 + 7 + 7;
  localparam int unsigned BytesPerAs      = 4;
  localparam int unsigned CommHeadBytes   = 3;
  localparam int unsigned BytesPerComm    = 4;
  localparam int unsigned AtomicAggBytes  = 3;
  localparam int unsigned AggregatorBytes = 9;
  localparam logic [rump_pkg::SizeW-1:0] SizeAtReset = 16'd4096;

  localparam int unsigned NumPhases   = 6;
  localparam int unsigned PhaseItems  = 300;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned CycleLimit  = 500000;

  typedef struct {
    rump_pkg::item_t   req;
    bit                typed;
    int unsigned       n_reports;
    rump_pkg::result_t rep0;
    rump_pkg::result_t rep1;
  } stim_row_t;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          item_valid   = 1'b0;
  logic                          item_ready;
  rump_pkg::item_t               item         = '0;
  logic                          result_valid;
  logic                          result_ready = 1'b0;
  rump_pkg::result_t             result;
  logic                          cfg_valid    = 1'b0;
  logic                          cfg_ready;
  logic [rump_pkg::SizeW-1:0]    cfg_data     = '0;

  // Predictor copy of the packer state and of the size register.
  logic [rump_pkg::OvhW-1:0]     ovh_bytes   = '0;
  logic [rump_pkg::SizeW-1:0]    space_limit = '0;
  logic [rump_pkg::SizeW-1:0]    open_bytes  = '0;
  logic [rump_pkg::CountW-1:0]   open_count  = '0;
  logic [rump_pkg::SizeW-1:0]    max_size    = SizeAtReset;

  rump_pkg::result_t   pending_reports[$];
  rump_pkg::result_t   step_reports[$];
  stim_row_t           stim_table[$];

  int unsigned burst_left      = 0;
  int unsigned items_sent      = 0;
  int unsigned groups_sent     = 0;
  int unsigned reports_checked = 0;
  int unsigned size_writes     = 0;
  int unsigned mismatches      = 0;
  int unsigned cycles          = 0;

  logic [15:0] ready_mask = 16'hFFFF;
  logic [3:0]  ready_idx  = '0;

  route_update_message_packer_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic rump_pkg::item_t mk_item(int unsigned plen, bit first, bit last,
                                              int unsigned as_cnt, int unsigned comm_cnt,
                                              bit atomic, bit aggr);
    rump_pkg::item_t it;
    it.prefix_len         = rump_pkg::PlenW'(plen);
    it.first_of_group     = first;
    it.last_of_group      = last;
    it.as_path_count      = rump_pkg::AsCntW'(as_cnt);
    it.community_count    = rump_pkg::CommCntW'(comm_cnt);
    it.atomic_agg         = atomic;
    it.aggregator_present = aggr;
    return it;
  endfunction

  function automatic rump_pkg::result_t mk_rep(int unsigned size, int unsigned count,
                                               bit grp_end, bit last);
    rump_pkg::result_t r;
    r.msg_bytes    = rump_pkg::SizeW'(size);
    r.prefix_count = rump_pkg::CountW'(count);
    r.group_end    = grp_end;
    r.last_result  = last;
    return r;
  endfunction

  function automatic void add_row(rump_pkg::item_t req, bit typed, int unsigned n_reports,
                                  rump_pkg::result_t rep0, rump_pkg::result_t rep1);
    stim_row_t row;
    row.req       = req;
    row.typed     = typed;
    row.n_reports = n_reports;
    row.rep0      = rep0;
    row.rep1      = rep1;
    stim_table.insert(stim_table.size(), row);
  endfunction

  // Mostly legal prefix lengths; now and then one above 32, which costs up to nine bytes.
  function automatic rump_pkg::item_t random_prefix();
    rump_pkg::item_t it;
    it.prefix_len         = ($urandom_range(0, 19) == 0)
                          ? rump_pkg::PlenW'($urandom_range(33, 63))
                          : rump_pkg::PlenW'($urandom_range(0, 32));
    it.first_of_group     = 1'($urandom_range(0, 1));
    it.last_of_group      = 1'($urandom_range(0, 1));
    it.as_path_count      = rump_pkg::AsCntW'($urandom_range(0, 255));
    it.community_count    = ($urandom_range(0, 3) == 0)
                          ? '0 : rump_pkg::CommCntW'($urandom_range(0, 63));
    it.atomic_agg         = 1'($urandom_range(0, 1));
    it.aggregator_present = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic void close_message(bit grp_end);
    rump_pkg::result_t r;
    r.msg_bytes    = rump_pkg::SizeW'(32'(ovh_bytes) + 32'(open_bytes));
    r.prefix_count = open_count;
    r.group_end    = grp_end;
    r.last_result  = 1'b0;
    step_reports.insert(step_reports.size(), r);
    open_bytes = '0;
    open_count = '0;
  endfunction

  // Greedy packing of one prefix; the reports it closes land in step_reports.
  function automatic void pack_prefix(rump_pkg::item_t it);
    int unsigned psize;
    int unsigned ovh;
    step_reports.delete();
    psize = 1 + (32'(it.prefix_len) + 7) / 8;
    if (it.first_of_group) begin
      // A group that never saw its last prefix is flushed under its own overhead.
      if (open_count != 0) close_message(1'b1);
      ovh = HeaderLenBytes + MandatoryBytes + BytesPerAs * 32'(it.as_path_count);
      if (it.community_count != 0)
        ovh = ovh + CommHeadBytes + BytesPerComm * 32'(it.community_count);
      if (it.atomic_agg) ovh = ovh + AtomicAggBytes;
      if (it.aggregator_present) ovh = ovh + AggregatorBytes;
      ovh_bytes = rump_pkg::OvhW'(ovh);
      // The limit saturates at zero when the overhead alone fills the message.
      space_limit = (max_size > rump_pkg::SizeW'(ovh_bytes))
                  ? max_size - rump_pkg::SizeW'(ovh_bytes) : '0;
      open_bytes = '0;
      open_count = '0;
    end
    if (open_count != 0 && 32'(open_bytes) + psize > 32'(space_limit))
      close_message(1'b0);
    open_bytes = rump_pkg::SizeW'(32'(open_bytes) + psize);
    open_count = open_count + 1'b1;
    if (it.last_of_group) close_message(1'b1);
    if (step_reports.size() > 0)
      step_reports[step_reports.size() - 1].last_result = 1'b1;
  endfunction

  // Offers one prefix request after the burst pacing, then predicts it on acceptance.
  task automatic send_item(rump_pkg::item_t it, bit use_model);
    int unsigned gap;
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    pack_prefix(it);
    if (use_model)
      foreach (step_reports[k]) pending_reports.insert(pending_reports.size(), step_reports[k]);
    items_sent++;
  endtask

  // The size register changes only while the packer is idle: every report is back
  // and a request that closes nothing has had time to leave the pipeline.
  task automatic set_max_size(logic [rump_pkg::SizeW-1:0] value);
    item_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_size = value;
    size_writes++;
  endtask

  // Mostly well-formed groups of random content. Some are long enough to overflow a
  // small limit, some are left open so that the next group start flushes them, and a
  // few carry an early last flag or stray prefixes that follow a group's end. The
  // last group of a phase is cut short so that the phase sends its target count.
  task automatic run_random_groups(int unsigned target);
    rump_pkg::item_t it;
    int unsigned     glen;
    int unsigned     done;
    int unsigned     strays;
    bit              closes;
    done = 0;
    while (done < target) begin
      glen   = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 400) : $urandom_range(1, 30);
      if (glen > target - done) glen = target - done;
      closes = ($urandom_range(0, 9) != 0);
      for (int unsigned k = 0; k < glen; k++) begin
        it = random_prefix();
        it.first_of_group = (k == 0);
        it.last_of_group  = (k == glen - 1) ? closes : ($urandom_range(0, 39) == 0);
        send_item(it, 1'b1);
        done++;
      end
      groups_sent++;
      if (done < target && $urandom_range(0, 11) == 0) begin
        strays = $urandom_range(1, 3);
        if (strays > target - done) strays = target - done;
        repeat (strays) begin
          it = random_prefix();
          it.first_of_group = 1'b0;
          send_item(it, 1'b1);
          done++;
        end
      end
    end
  endtask

  // Receiver: every accepted report is compared with the oldest prediction. Ready
  // follows a window mask whose first bit is always set, so a stall never outlasts
  // one window; some windows are fully open.
  always @(posedge clk) begin : report_check
    rump_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report: msg_bytes %0d prefix_count %0d",
               result.msg_bytes, result.prefix_count);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (result.msg_bytes !== want.msg_bytes) begin
          $error("msg_bytes: expected %0d, got %0d", want.msg_bytes, result.msg_bytes);
          mismatches++;
        end
        if (result.prefix_count !== want.prefix_count) begin
          $error("prefix_count: expected %0d, got %0d", want.prefix_count, result.prefix_count);
          mismatches++;
        end
        if (result.group_end !== want.group_end) begin
          $error("group_end: expected %0d, got %0d", want.group_end, result.group_end);
          mismatches++;
        end
        if (result.last_result !== want.last_result) begin
          $error("last_result: expected %0d, got %0d", want.last_result, result.last_result);
          mismatches++;
        end
      end
    end
    result_ready <= ready_mask[ready_idx];
    ready_idx    <= ready_idx + 1'b1;
    if (ready_idx == 4'hF) begin
      case ($urandom_range(0, 3))
        0:       ready_mask <= 16'hFFFF;
        1:       ready_mask <= 16'($urandom) | 16'h0001;
        2:       ready_mask <= (16'($urandom) & 16'($urandom)) | 16'h0001;
        default: ready_mask <= 16'($urandom) | 16'($urandom) | 16'h0001;
      endcase
    end
  end

  initial begin : main_seq
    logic [rump_pkg::SizeW-1:0] limits[NumPhases];
    rump_pkg::result_t          none;
    none = '0;

    // Rows with typed reports can be worked out by hand: the first three run on the
    // all-zero state after reset, where the limit is zero and every message holds
    // a single prefix. The rest go through the predictor.
    add_row(mk_item(0, 0, 1, 0, 0, 0, 0), 1'b1, 1, mk_rep(1, 1, 1, 1), none);
    add_row(mk_item(8, 0, 0, 0, 0, 0, 0), 1'b1, 0, none, none);
    add_row(mk_item(9, 0, 0, 0, 0, 0, 0), 1'b1, 1, mk_rep(2, 1, 0, 1), none);
    // Group start flushes the open message, then the smallest overhead of 53 bytes.
    add_row(mk_item(32, 1, 1, 0, 0, 0, 0), 1'b1, 2, mk_rep(3, 1, 1, 0), mk_rep(58, 1, 1, 1));
    // Largest overhead, 1340 bytes, with the longest 6-bit prefix at nine bytes.
    add_row(mk_item(63, 1, 1, 255, 63, 1, 1), 1'b1, 1, mk_rep(1349, 1, 1, 1), none);
    add_row(mk_item(24, 1, 0, 2, 1, 0, 1), 1'b0, 0, none, none);
    add_row(mk_item(0, 0, 0, 255, 63, 1, 1), 1'b0, 0, none, none);
    add_row(mk_item(33, 0, 0, 0, 0, 0, 0), 1'b0, 0, none, none);
    add_row(mk_item(40, 0, 0, 0, 0, 0, 0), 1'b0, 0, none, none);
    add_row(mk_item(16, 0, 1, 0, 0, 0, 0), 1'b0, 0, none, none);
    add_row(mk_item(12, 1, 0, 170, 42, 1, 0), 1'b0, 0, none, none);
    add_row(mk_item(7, 0, 0, 0, 0, 0, 0), 1'b0, 0, none, none);
    // This group start arrives while the previous group is still open.
    add_row(mk_item(1, 1, 0, 85, 21, 0, 1), 1'b0, 0, none, none);
    add_row(mk_item(31, 0, 1, 0, 0, 0, 0), 1'b0, 0, none, none);
    // Prefixes after the group's end reuse the stored attributes.
    add_row(mk_item(20, 0, 0, 0, 0, 0, 0), 1'b0, 0, none, none);
    add_row(mk_item(48, 0, 1, 0, 0, 0, 0), 1'b0, 0, none, none);
    add_row(mk_item(0, 1, 1, 0, 0, 0, 0), 1'b1, 1, mk_rep(54, 1, 1, 1), none);
    add_row(mk_item(32, 1, 1, 255, 0, 1, 0), 1'b0, 0, none, none);

    limits[0] = 16'd2048;
    limits[1] = 16'd65535;
    limits[2] = rump_pkg::SizeW'($urandom_range(2048, 65535));
    limits[3] = 16'd2048;
    limits[4] = rump_pkg::SizeW'($urandom_range(2048, 8192));
    limits[5] = SizeAtReset;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      send_item(stim_table[i].req, !stim_table[i].typed);
      if (stim_table[i].typed && stim_table[i].n_reports >= 1)
        pending_reports.insert(pending_reports.size(), stim_table[i].rep0);
      if (stim_table[i].typed && stim_table[i].n_reports >= 2)
        pending_reports.insert(pending_reports.size(), stim_table[i].rep1);
    end

    for (int unsigned p = 0; p < NumPhases; p++) begin
      set_max_size(limits[p]);
      run_random_groups(PhaseItems);
    end

    item_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Packed %0d prefix requests in %0d random groups plus a directed table,",
             items_sent, groups_sent);
    $display("checking %0d message reports under %0d size limit settings.",
             reports_checked, size_writes);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
